/* src/tcce_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

    // Fixed widths of the item and result fields.
    localparam int OP_W      = 1;
    localparam int BYTE_W    = 8;
    localparam int ROW_W     = 5;
    localparam int COL_W     = 7;
    localparam int INDEX_W   = 11;
    localparam int CELL_W    = 16;
    localparam int BG_W      = 3;
    localparam int FG_W      = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 1'b1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUT  = 1'b0;
    localparam logic [OP_W-1:0] OP_READ = 1'b1;

    // Character codes.
    localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
    localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_FORMFEED  = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_FIRST_PRINT = 8'd32;
    localparam logic [BYTE_W-1:0] CH_LAST_PRINT  = 8'd126;

    // Colors and the blank cell.
    localparam logic [FG_W-1:0] CL_CYAN   = 4'h3;
    localparam logic [FG_W-1:0] CL_BRIGHT = 4'h8;
    localparam logic [BG_W-1:0] BG_RESET = 3'd0;
    localparam logic [FG_W-1:0] FG_RESET = CL_CYAN | CL_BRIGHT;
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

    typedef enum logic [2:0] {
        CLS_PRINT,
        CLS_BACKSPACE,
        CLS_TAB,
        CLS_NEWLINE,
        CLS_FORMFEED,
        CLS_RETURN,
        CLS_READ,
        CLS_IGNORE
    } t_item_class;

    typedef struct packed {
        logic accept;
        logic scroll_step;
        logic fill_step;
        logic cnt_inc;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_item_class cls;
        logic        scroll_needed;
        logic        move_end;
        logic        cnt_last;
        logic        out_free;
    } t_sts;

endpackage

`default_nettype wire

/* src/tcce_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcce_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  tcce_pkg::t_sts    i_sts,
    output tcce_pkg::t_cmd    o_cmd
);
    import tcce_pkg::*;

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SCROLL = 6'b000100,
        S_FILL   = 6'b001000,
        S_CLEAR  = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.fill_step = 1'b1;
                o_cmd.cnt_inc   = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.cls == CLS_IGNORE) begin
                        n_state = S_IDLE;
                    end else if (i_sts.cls == CLS_FORMFEED) begin
                        n_state = S_CLEAR;
                    end else if (i_sts.scroll_needed) begin
                        n_state = S_SCROLL;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCROLL: begin
                o_cmd.scroll_step = 1'b1;
                if (i_sts.move_end) begin
                    // The fill of the bottom row starts at the current count.
                    n_state = S_FILL;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                o_cmd.cnt_inc   = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_DONE;
                end
            end
            S_CLEAR: begin
                o_cmd.fill_step = 1'b1;
                o_cmd.cnt_inc   = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // A result is produced only by an item that needs one.
    property p_done_after_real_item;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_sts.cls == CLS_IGNORE) |=> (r_state == S_IDLE);
    endproperty
    a_done_after_real_item: assert property (p_done_after_real_item)
        else $error("ignored byte left the idle state");

    // Nothing is accepted during the clearing pass after reset.
    property p_no_accept_in_init;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !o_cmd.accept;
    endproperty
    a_no_accept_in_init: assert property (p_no_accept_in_init)
        else $error("item accepted during clearing pass");

    // A result is loaded only when the output stage is empty or its previous result is transferring.
    property p_load_needs_room;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free;
    endproperty
    a_load_needs_room: assert property (p_load_needs_room)
        else $error("result loaded over a pending result");

endmodule

`default_nettype wire

/* src/tcce_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcce_dp #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_cfg_we,
    input  wire  [tcce_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire  [tcce_pkg::CFG_DAT_W-1:0]         i_cfg_data,
    input  wire  [tcce_pkg::OP_W-1:0]              i_op,
    input  wire  [tcce_pkg::BYTE_W-1:0]            i_char_byte,
    input  wire  [tcce_pkg::ROW_W-1:0]             i_read_row,
    input  wire  [tcce_pkg::COL_W-1:0]             i_read_column,
    input  wire                                    i_ready,
    output logic                                   o_valid,
    output logic [tcce_pkg::ROW_W-1:0]             o_cursor_row,
    output logic [tcce_pkg::COL_W-1:0]             o_cursor_column,
    output logic [tcce_pkg::INDEX_W-1:0]           o_cursor_index,
    output logic [tcce_pkg::CELL_W-1:0]            o_cell_word,
    input  tcce_pkg::t_cmd                         i_cmd,
    output tcce_pkg::t_sts                         o_sts
);
    import tcce_pkg::*;

    localparam int N_CELLS = ROWS * COLUMNS;
    localparam int N_MOVE  = (ROWS - 1) * COLUMNS;
    localparam int AW      = $clog2(N_CELLS);
    localparam int CNTW    = $clog2(N_CELLS + 1);
    localparam int RW      = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int CW      = $clog2(COLUMNS);
    localparam int CXW     = CW + 1;

    logic [CELL_W-1:0] r_mem [N_CELLS];
    logic [CELL_W-1:0] r_rd_data;

    logic [BG_W-1:0]   r_bg;
    logic [FG_W-1:0]   r_fg;
    logic [RW-1:0]     r_row;
    logic [RW-1:0]     n_row;
    logic [CW-1:0]     r_col;
    logic [CW-1:0]     n_col;
    logic [CNTW-1:0]   r_cnt;
    logic              r_cell_ok;
    logic              r_out_valid;

    t_item_class       cls;
    logic              wrap;
    logic              scroll;
    logic [CXW-1:0]    tab_col;
    logic              read_in_range;
    logic [AW-1:0]     read_addr;
    logic [AW-1:0]     cur_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [CELL_W-1:0] mem_wd;
    logic              mem_re;
    logic [AW-1:0]     mem_ra;

    // Item decode.
    always_comb begin
        if (i_op == OP_READ) begin
            cls = CLS_READ;
        end else if (i_char_byte >= CH_FIRST_PRINT && i_char_byte <= CH_LAST_PRINT) begin
            cls = CLS_PRINT;
        end else begin
            unique case (i_char_byte)
                CH_BACKSPACE: cls = CLS_BACKSPACE;
                CH_TAB:       cls = CLS_TAB;
                CH_NEWLINE:   cls = CLS_NEWLINE;
                CH_FORMFEED:  cls = CLS_FORMFEED;
                CH_RETURN:    cls = CLS_RETURN;
                default:      cls = CLS_IGNORE;
            endcase
        end
    end

    assign read_in_range = (32'(i_read_row) < ROWS) && (32'(i_read_column) < COLUMNS);
    assign read_addr = AW'(32'(i_read_row) * COLUMNS + 32'(i_read_column));
    assign cur_addr  = AW'(32'(r_row) * COLUMNS + 32'(r_col));
    assign tab_col   = (CXW'(r_col) | CXW'(7)) + CXW'(1);

    // Cursor motion for the incoming item.
    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        wrap   = 1'b0;
        scroll = 1'b0;
        case (cls)
            CLS_PRINT: begin
                if (32'(r_col) == COLUMNS - 1) begin
                    wrap = 1'b1;
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
            CLS_TAB: begin
                if (32'(tab_col) >= COLUMNS) begin
                    wrap = 1'b1;
                end else begin
                    n_col = CW'(tab_col);
                end
            end
            CLS_NEWLINE: begin
                wrap = 1'b1;
            end
            CLS_BACKSPACE: begin
                if (r_col != '0) begin
                    n_col = r_col - CW'(1);
                end
            end
            CLS_RETURN: begin
                n_col = '0;
            end
            CLS_FORMFEED: begin
                n_row = '0;
                n_col = '0;
            end
            default: begin
            end
        endcase
        if (wrap) begin
            n_col = '0;
            if (32'(r_row) == ROWS - 1) begin
                scroll = 1'b1;
            end else begin
                n_row = r_row + RW'(1);
            end
        end
    end

    // Screen memory port selection.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = cur_addr;
        mem_wd = BLANK_CELL;
        mem_re = 1'b0;
        mem_ra = read_addr;
        if (i_cmd.accept && cls == CLS_PRINT) begin
            mem_we = 1'b1;
            mem_wd = {1'b0, r_bg, r_fg, i_char_byte};
        end else if (i_cmd.scroll_step && r_cnt != '0) begin
            // Each cell moves one row up, written in the cycle after its read.
            mem_we = 1'b1;
            mem_wa = AW'(r_cnt - CNTW'(1));
            mem_wd = r_rd_data;
        end else if (i_cmd.fill_step) begin
            mem_we = 1'b1;
            mem_wa = AW'(r_cnt);
        end
        if (i_cmd.accept && cls == CLS_READ && read_in_range) begin
            mem_re = 1'b1;
        end else if (i_cmd.scroll_step && !o_sts.move_end) begin
            mem_re = 1'b1;
            mem_ra = AW'(32'(r_cnt) + COLUMNS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg        <= BG_RESET;
            r_fg        <= FG_RESET;
            r_row       <= '0;
            r_col       <= '0;
            r_cnt       <= '0;
            r_cell_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_BACKGROUND) begin
                    r_bg <= i_cfg_data[BG_W-1:0];
                end else if (i_cfg_index == CFG_FOREGROUND) begin
                    r_fg <= i_cfg_data[FG_W-1:0];
                end
            end
            if (i_cmd.accept) begin
                r_row     <= n_row;
                r_col     <= n_col;
                r_cnt     <= '0;
                r_cell_ok <= (cls == CLS_READ) && read_in_range;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CNTW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_cursor_row    <= ROW_W'(r_row);
            o_cursor_column <= COL_W'(r_col);
            o_cursor_index  <= INDEX_W'(32'(r_row) * COLUMNS + 32'(r_col));
            o_cell_word     <= r_cell_ok ? r_rd_data : '0;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_sts.cls           = cls;
    assign o_sts.scroll_needed = scroll;
    assign o_sts.move_end      = (32'(r_cnt) == N_MOVE);
    assign o_sts.cnt_last      = (32'(r_cnt) == N_CELLS - 1);
    assign o_sts.out_free      = !r_out_valid || i_ready;

    property p_col_range;
        @(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < COLUMNS;
    endproperty
    a_col_range: assert property (p_col_range)
        else $error("cursor column out of range");

    property p_row_range;
        @(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) < ROWS;
    endproperty
    a_row_range: assert property (p_row_range)
        else $error("cursor row out of range");

    property p_scroll_cursor;
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && scroll) |=> (32'(r_row) == ROWS - 1 && r_col == '0);
    endproperty
    a_scroll_cursor: assert property (p_scroll_cursor)
        else $error("cursor not at start of bottom row after scroll");

endmodule

`default_nettype wire

/* src/text_console_char_engine_core.sv */
// A put or read item is taken in idle; no new item is taken until a done state has loaded
// its result into the registered output stage, once that stage is free. Ignored bytes leave
// the engine idle and give no result. A line feed at the bottom row scrolls the screen up a
// row and blanks the bottom row, and a form feed blanks the whole screen, cell by cell through
// the single write port of the screen memory. Reset (synchronous, active low) homes the cursor
// and loads the default colors; a clearing pass then blanks the screen, accepting no item.
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_engine_core #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [tcce_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [tcce_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire  [tcce_pkg::OP_W-1:0]          i_op,
    input  wire  [tcce_pkg::BYTE_W-1:0]        i_char_byte,
    input  wire  [tcce_pkg::ROW_W-1:0]         i_read_row,
    input  wire  [tcce_pkg::COL_W-1:0]         i_read_column,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic [tcce_pkg::ROW_W-1:0]         o_cursor_row,
    output logic [tcce_pkg::COL_W-1:0]         o_cursor_column,
    output logic [tcce_pkg::INDEX_W-1:0]       o_cursor_index,
    output logic [tcce_pkg::CELL_W-1:0]        o_cell_word
);
    import tcce_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tcce_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tcce_dp #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_char_byte     (i_char_byte),
        .i_read_row      (i_read_row),
        .i_read_column   (i_read_column),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_column (o_cursor_column),
        .o_cursor_index  (o_cursor_index),
        .o_cell_word     (o_cell_word),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
    import tcce_pkg::*;

    localparam int SCREEN_ROWS    = 25;
    localparam int SCREEN_COLS    = 80;
    localparam int SCREEN_CELLS   = SCREEN_ROWS * SCREEN_COLS;
    localparam int CLK_PERIOD     = 10;
    // A scroll walks the whole screen memory; this covers it with margin.
    localparam int SETTLE_CYCLES  = SCREEN_CELLS + SCREEN_COLS + 16;
    localparam int WATCHDOG_LIMIT = 4 * SETTLE_CYCLES;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_REPORTS  = 500;

    typedef struct {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   column;
        logic [INDEX_W-1:0] index;
        logic [CELL_W-1:0]  cell_word;
    } cursor_report_t;

    // Shadow copy of the console: screen, cursor and colors, plus the
    // cursor reports still owed by the block.
    class console_shadow;
        logic [CELL_W-1:0] cells [SCREEN_CELLS];
        int unsigned       row;
        int unsigned       col;
        logic [BG_W-1:0]   bg;
        logic [FG_W-1:0]   fg;
        cursor_report_t    pending [$];
        int unsigned       reports_noted;
        int unsigned       reports_seen;
        int unsigned       mismatches;
        int unsigned       reads;
        int unsigned       scrolls;
        int unsigned       clears;
        int unsigned       ignored;

        function new();
            bg = BG_RESET;
            fg = FG_RESET;
            clear_screen();
        endfunction

        function void clear_screen();
            foreach (cells[i])
                cells[i] = BLANK_CELL;
            row = 0;
            col = 0;
        endfunction

        function void line_feed();
            int i;
            col = 0;
            row++;
            if (row >= SCREEN_ROWS) begin
                row = SCREEN_ROWS - 1;
                for (i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++)
                    cells[i] = cells[i + SCREEN_COLS];
                for (i = (SCREEN_ROWS - 1) * SCREEN_COLS; i < SCREEN_CELLS; i++)
                    cells[i] = BLANK_CELL;
                scrolls++;
            end
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DAT_W-1:0] data);
            if (idx == CFG_BACKGROUND)
                bg = data[BG_W-1:0];
            else if (idx == CFG_FOREGROUND)
                fg = data[FG_W-1:0];
        endfunction

        function void apply_item(input logic [OP_W-1:0]   op,
                                 input logic [BYTE_W-1:0] ch,
                                 input logic [ROW_W-1:0]  rr,
                                 input logic [COL_W-1:0]  rc);
            cursor_report_t rep;
            rep.cell_word = '0;
            if (op == OP_READ) begin
                reads++;
                if (rr < SCREEN_ROWS && rc < SCREEN_COLS)
                    rep.cell_word = cells[rr * SCREEN_COLS + rc];
            end else if (ch >= CH_FIRST_PRINT && ch <= CH_LAST_PRINT) begin
                cells[row * SCREEN_COLS + col] = {1'b0, bg, fg, ch};
                col++;
                if (col >= SCREEN_COLS)
                    line_feed();
            end else begin
                case (ch)
                    CH_BACKSPACE: begin
                        if (col != 0)
                            col--;
                    end
                    CH_TAB: begin
                        col += 8 - (col % 8);
                        if (col >= SCREEN_COLS)
                            line_feed();
                    end
                    CH_NEWLINE: line_feed();
                    CH_FORMFEED: begin
                        clear_screen();
                        clears++;
                    end
                    CH_RETURN: col = 0;
                    default: begin
                        ignored++;
                        return;
                    end
                endcase
            end
            rep.row    = ROW_W'(row);
            rep.column = COL_W'(col);
            rep.index  = INDEX_W'(row * SCREEN_COLS + col);
            pending.push_back(rep);
            reports_noted++;
        endfunction

        function void compare_field(input string field_name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, field_name, want, got);
            end
        endfunction

        function void check_report(input logic [ROW_W-1:0]   r,
                                   input logic [COL_W-1:0]   c,
                                   input logic [INDEX_W-1:0] idx,
                                   input logic [CELL_W-1:0]  w);
            cursor_report_t want;
            if (pending.size() == 0) begin
                mismatches++;
                $display("%0t: cursor report with none expected, row %0d column %0d cell 0x%h",
                         $time, r, c, w);
                return;
            end
            want = pending.pop_front();
            reports_seen++;
            compare_field("cursor_row", 32'(want.row), 32'(r));
            compare_field("cursor_column", 32'(want.column), 32'(c));
            compare_field("cursor_index", 32'(want.index), 32'(idx));
            compare_field("cell_word", 32'(want.cell_word), 32'(w));
        endfunction

        function int unsigned outstanding();
            return pending.size();
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = CFG_BACKGROUND;
    logic [CFG_DAT_W-1:0] i_cfg_data    = '0;
    logic                 i_valid       = 1'b0;
    logic                 o_ready;
    logic [OP_W-1:0]      i_op          = OP_PUT;
    logic [BYTE_W-1:0]    i_char_byte   = '0;
    logic [ROW_W-1:0]     i_read_row    = '0;
    logic [COL_W-1:0]     i_read_column = '0;
    logic                 o_valid;
    logic                 i_ready       = 1'b0;
    logic [ROW_W-1:0]     o_cursor_row;
    logic [COL_W-1:0]     o_cursor_column;
    logic [INDEX_W-1:0]   o_cursor_index;
    logic [CELL_W-1:0]    o_cell_word;

    console_shadow shadow;
    int unsigned   tx_idle_pct       = 0;
    int unsigned   rx_stall_pct      = 0;
    int unsigned   tx_burst_left     = 0;
    int unsigned   rx_burst_left     = 0;
    int unsigned   ready_hold_cycles = 0;
    int unsigned   quiet_cycles      = 0;

    text_console_char_engine_core #(
        .ROWS    (SCREEN_ROWS),
        .COLUMNS (SCREEN_COLS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_char_byte     (i_char_byte),
        .i_read_row      (i_read_row),
        .i_read_column   (i_read_column),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_column (o_cursor_column),
        .o_cursor_index  (o_cursor_index),
        .o_cell_word     (o_cell_word)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Receiver side: random stalls, stall-free bursts, and the long hold-off.
    initial begin
        forever begin
            @(posedge i_clk);
            if (ready_hold_cycles != 0) begin
                i_ready <= 1'b0;
                repeat (ready_hold_cycles) @(posedge i_clk);
                ready_hold_cycles = 0;
            end
            if (rx_burst_left != 0) begin
                rx_burst_left--;
                i_ready <= 1'b1;
            end else begin
                if ($urandom_range(99) < 3)
                    rx_burst_left = $urandom_range(40, 10);
                i_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            shadow.check_report(o_cursor_row, o_cursor_column, o_cursor_index, o_cell_word);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d reports outstanding",
                     $time, quiet_cycles, shadow.outstanding());
            $display("** text_console_char_engine_core: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Valid is never lowered after a transfer here; the next call either
    // keeps it high with a new payload or opens a gap.
    task automatic send_item(input logic [OP_W-1:0]   op,
                             input logic [BYTE_W-1:0] ch,
                             input logic [ROW_W-1:0]  rr,
                             input logic [COL_W-1:0]  rc);
        if (tx_burst_left != 0) begin
            tx_burst_left--;
        end else begin
            if ($urandom_range(99) < 3)
                tx_burst_left = $urandom_range(40, 10);
            if ($urandom_range(99) < tx_idle_pct) begin
                i_valid <= 1'b0;
                do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
            end
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_char_byte   <= ch;
        i_read_row    <= rr;
        i_read_column <= rc;
        do @(posedge i_clk); while (!o_ready);
        shadow.apply_item(op, ch, rr, rc);
    endtask

    task automatic put_byte(input logic [BYTE_W-1:0] ch);
        send_item(OP_PUT, ch, ROW_W'($urandom), COL_W'($urandom));
    endtask

    task automatic read_cell(input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
        send_item(OP_READ, BYTE_W'($urandom), rr, rc);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (shadow.outstanding() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_colors(input logic [CFG_DAT_W-1:0] bg_data,
                              input logic [CFG_DAT_W-1:0] fg_data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BACKGROUND;
        i_cfg_data  <= bg_data;
        @(posedge i_clk);
        shadow.set_register(CFG_BACKGROUND, bg_data);
        i_cfg_index <= CFG_FOREGROUND;
        i_cfg_data  <= fg_data;
        @(posedge i_clk);
        shadow.set_register(CFG_FOREGROUND, fg_data);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly runs of text with controls mixed in, newlines and read-backs;
    // the rest is raw bytes and the odd screen clear.
    task automatic run_console_traffic(input int unsigned target);
        int unsigned pick;
        int unsigned len;
        int unsigned sel;
        int unsigned i;
        while (shadow.reports_noted < target) begin
            pick = $urandom_range(199);
            if (pick < 100) begin
                len = $urandom_range(40, 1);
                for (i = 0; i < len; i++) begin
                    sel = $urandom_range(99);
                    if (sel < 6)
                        put_byte(CH_TAB);
                    else if (sel < 9)
                        put_byte(CH_BACKSPACE);
                    else if (sel < 11)
                        put_byte(CH_RETURN);
                    else
                        put_byte(BYTE_W'($urandom_range(CH_LAST_PRINT, CH_FIRST_PRINT)));
                end
            end else if (pick < 124) begin
                put_byte(CH_NEWLINE);
            end else if (pick < 164) begin
                len = $urandom_range(4, 1);
                for (i = 0; i < len; i++) begin
                    sel = $urandom_range(9);
                    if (sel < 7)
                        read_cell(ROW_W'($urandom_range(SCREEN_ROWS - 1)),
                                  COL_W'($urandom_range(SCREEN_COLS - 1)));
                    else if (sel < 9)
                        read_cell(ROW_W'(shadow.row), COL_W'($urandom_range(SCREEN_COLS - 1)));
                    else
                        read_cell(ROW_W'($urandom), COL_W'($urandom));
                end
            end else if (pick < 184) begin
                len = $urandom_range(3, 1);
                for (i = 0; i < len; i++)
                    put_byte(BYTE_W'($urandom));
            end else if (pick < 198) begin
                len = $urandom_range(6, 2);
                for (i = 0; i < len; i++)
                    put_byte(CH_NEWLINE);
            end else begin
                put_byte(CH_FORMFEED);
            end
        end
    endtask

    initial begin
        logic [CFG_DAT_W-1:0] bg_set [4];
        logic [CFG_DAT_W-1:0] fg_set [4];
        int unsigned          tx_pct [4];
        int unsigned          rx_pct [4];
        int                   p;

        shadow = new();
        bg_set = '{4'hF, 4'h0, CFG_DAT_W'($urandom), 4'h7};
        fg_set = '{4'h0, 4'hF, CFG_DAT_W'($urandom), 4'hF};
        tx_pct = '{0, 86, 0, 35};
        rx_pct = '{0, 0, 86, 35};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset colors still in place.
        read_cell(0, 0);
        put_byte(8'h41);
        put_byte(CH_FIRST_PRINT);
        put_byte(CH_LAST_PRINT);
        put_byte(CH_LAST_PRINT + 8'd1);
        put_byte(CH_FIRST_PRINT - 8'd1);
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(CH_BACKSPACE);
        read_cell(0, 2);
        put_byte(CH_RETURN);
        put_byte(CH_BACKSPACE);
        put_byte(CH_TAB);
        put_byte(CH_TAB);
        put_byte(8'h7A);
        put_byte(CH_NEWLINE);
        read_cell(0, 1);
        read_cell(ROW_W'(SCREEN_ROWS - 1), COL_W'(SCREEN_COLS - 1));
        read_cell(ROW_W'(SCREEN_ROWS), 0);
        read_cell(0, COL_W'(SCREEN_COLS));
        read_cell('1, '1);
        put_byte(CH_FORMFEED);
        read_cell(0, 0);
        put_byte(8'h80);
        put_byte(8'h0B);

        for (p = 0; p < 4; p++) begin
            settle();
            set_colors(bg_set[p], fg_set[p]);
            tx_idle_pct  = tx_pct[p];
            rx_stall_pct = rx_pct[p];
            if (p == 0)
                ready_hold_cycles = HOLD_CYCLES;
            run_console_traffic(shadow.reports_noted + PHASE_REPORTS);
        end

        settle();
        $display("Checked %0d cursor reports: %0d cell reads, %0d scrolls, %0d screen clears.",
                 shadow.reports_seen, shadow.reads, shadow.scrolls, shadow.clears);
        $display("%0d bytes were ignored; four color settings and %0d mismatches were seen.",
                 shadow.ignored, shadow.mismatches);
        if (shadow.mismatches == 0)
            $display("** text_console_char_engine_core: PASSED **");
        else
            $display("** text_console_char_engine_core: FAILED **");
        $finish;
    end

endmodule
